FILE: rtl/sle_pkg.sv
// shared types, key codes and the scancode to ascii table for the line editor
// no dependencies
`default_nettype none

package sle_pkg;

    // special scancodes
    localparam logic [7:0] KEY_ENTER  = 8'h1C;
    localparam logic [7:0] KEY_BACK   = 8'h0E;

    // screen attribute and fill character
    localparam logic [7:0] ATTR_TEXT  = 8'h07;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // result targets
    localparam logic TGT_SCREEN = 1'b0;
    localparam logic TGT_LINE   = 1'b1;

    // one result transfer
    typedef struct packed {
        logic        target;
        logic [10:0] location;
        logic [15:0] value;
        logic        line_done;
    } res_t;

    // results of one scancode handed from the editor to the output queue
    typedef struct packed {
        logic            load;
        logic [1:0]      cnt;
        res_t [2:0]      item;
    } batch_t;

    // set-1 make code to lower-case ascii, 0 for unmapped
    function automatic logic [7:0] key_to_ascii(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h02: ch = "1";
            7'h03: ch = "2";
            7'h04: ch = "3";
            7'h05: ch = "4";
            7'h06: ch = "5";
            7'h07: ch = "6";
            7'h08: ch = "7";
            7'h09: ch = "8";
            7'h0A: ch = "9";
            7'h0B: ch = "0";
            7'h0C: ch = "-";
            7'h0D: ch = "=";
            7'h10: ch = "q";
            7'h11: ch = "w";
            7'h12: ch = "e";
            7'h13: ch = "r";
            7'h14: ch = "t";
            7'h15: ch = "y";
            7'h16: ch = "u";
            7'h17: ch = "i";
            7'h18: ch = "o";
            7'h19: ch = "p";
            7'h1A: ch = "[";
            7'h1B: ch = "]";
            7'h1E: ch = "a";
            7'h1F: ch = "s";
            7'h20: ch = "d";
            7'h21: ch = "f";
            7'h22: ch = "g";
            7'h23: ch = "h";
            7'h24: ch = "j";
            7'h25: ch = "k";
            7'h26: ch = "l";
            7'h27: ch = ";";
            7'h28: ch = 8'h27;
            7'h2B: ch = 8'h5C;
            7'h2C: ch = "z";
            7'h2D: ch = "x";
            7'h2E: ch = "c";
            7'h2F: ch = "v";
            7'h30: ch = "b";
            7'h31: ch = "n";
            7'h32: ch = "m";
            7'h33: ch = ",";
            7'h34: ch = ".";
            7'h35: ch = "/";
            7'h39: ch = CHAR_SPACE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sle_cfg.sv
// apb register file holding line_capacity
// depends on nothing beyond the apb signals
`default_nettype none

module sle_cfg
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [8:0]       line_capacity
);

    logic [8:0] cap_reg;
    logic [8:0] cap_next;
    logic       wr_hit;

    // write decode, the only word answers at every paddr with bit 2 clear
    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready && !paddr[2];

    always_comb
    begin
        cap_next = cap_reg;
        if (wr_hit)
        begin
            cap_next = pwdata[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 9'd256;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // read back
    assign prdata        = paddr[2] ? 32'd0 : {23'd0, cap_reg};
    assign line_capacity = cap_reg;

endmodule

`default_nettype wire

FILE: rtl/sle_core.sv
// editor core: scancode register, cursor and line state, result computation
// depends on sle_pkg
`default_nettype none

module sle_core
    import sle_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25,
    parameter int LINE_MAX    = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       key_valid,
    output logic            key_stall,
    input  wire logic [7:0] scancode,
    input  wire logic [8:0] line_capacity,
    input  wire logic       take,
    output batch_t          batch
);

    localparam logic [6:0]  COL_LAST = 7'(SCREEN_COLS - 1);
    localparam logic [4:0]  ROW_LAST = 5'(SCREEN_ROWS - 1);
    localparam logic [11:0] COLS12   = 12'(SCREEN_COLS);
    localparam logic [8:0]  LMAX9    = 9'(LINE_MAX);

    logic [7:0] code_reg;
    logic       full_reg;
    logic       full_next;
    logic [4:0] row_reg;
    logic [4:0] row_next;
    logic [6:0] col_reg;
    logic [6:0] col_next;
    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic       accept;
    logic       move;

    function automatic logic [10:0] cell_of(input logic [4:0] r, input logic [6:0] c);
        logic [11:0] sum;
        sum = 12'(r) * COLS12 + 12'(c);
        return sum[10:0];
    endfunction

    function automatic logic [4:0] row_inc(input logic [4:0] r);
        return (r == ROW_LAST) ? 5'd0 : r + 5'd1;
    endfunction

    // input transfer and hand-off to the output queue
    assign move      = full_reg && take;
    assign key_stall = full_reg && !take;
    assign accept    = key_valid && !key_stall;

    always_comb
    begin
        full_next = full_reg;
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (move)
        begin
            full_next = 1'b0;
        end
    end

    // result computation and next editor state
    always_comb
    begin
        logic [8:0] eff_cap;
        logic [7:0] ch;
        logic       fits;
        logic [4:0] r1, r2, r3;
        logic [6:0] c1, c2, c3;
        logic       bs1, bs2;
        res_t       e1, e2, e3;

        eff_cap  = (line_capacity > LMAX9) ? LMAX9 : line_capacity;
        ch       = key_to_ascii(code_reg[6:0]);
        fits     = (eff_cap != 9'd0) && (({1'b0, pos_reg} + 9'd1) < eff_cap);

        batch      = '0;
        batch.load = move;
        row_next   = row_reg;
        col_next   = col_reg;
        pos_next   = pos_reg;

        // backspace echo: step back, space, step back
        bs1 = 1'b1;
        r1  = row_reg;
        c1  = col_reg;
        if (col_reg != 7'd0)
        begin
            c1 = col_reg - 7'd1;
        end
        else if (row_reg != 5'd0)
        begin
            r1 = row_reg - 5'd1;
            c1 = COL_LAST;
        end
        else
        begin
            bs1 = 1'b0;
        end
        if (c1 == COL_LAST)
        begin
            c2 = 7'd0;
            r2 = row_inc(r1);
        end
        else
        begin
            c2 = c1 + 7'd1;
            r2 = r1;
        end
        bs2 = 1'b1;
        r3  = r2;
        c3  = c2;
        if (c2 != 7'd0)
        begin
            c3 = c2 - 7'd1;
        end
        else if (r2 != 5'd0)
        begin
            r3 = r2 - 5'd1;
            c3 = COL_LAST;
        end
        else
        begin
            bs2 = 1'b0;
        end
        e1 = '{TGT_SCREEN, cell_of(r1, c1), {ATTR_TEXT, CHAR_SPACE}, 1'b0};
        e2 = e1;
        e3 = '{TGT_SCREEN, cell_of(r3, c3), {ATTR_TEXT, CHAR_SPACE}, 1'b0};

        if (code_reg == KEY_ENTER)
        begin
            batch.cnt     = 2'd1;
            batch.item[0] = '{TGT_LINE, {3'd0, pos_reg}, 16'h0000, 1'b1};
            pos_next      = 8'd0;
            col_next      = 7'd0;
            row_next      = row_inc(row_reg);
        end
        else if (code_reg == KEY_BACK)
        begin
            if (pos_reg != 8'd0)
            begin
                pos_next = pos_reg - 8'd1;
                row_next = r3;
                col_next = c3;
                if (bs1)
                begin
                    batch.item[0] = e1;
                    batch.item[1] = e2;
                    batch.item[2] = e3;
                    batch.cnt     = bs2 ? 2'd3 : 2'd2;
                end
                else
                begin
                    batch.item[0] = e2;
                    batch.item[1] = e3;
                    batch.cnt     = bs2 ? 2'd2 : 2'd1;
                end
            end
        end
        else if (!code_reg[7] && ch != 8'h00 && fits)
        begin
            batch.cnt     = 2'd2;
            batch.item[0] = '{TGT_LINE, {3'd0, pos_reg}, {8'h00, ch}, 1'b0};
            batch.item[1] = '{TGT_SCREEN, cell_of(row_reg, col_reg), {ATTR_TEXT, ch}, 1'b0};
            pos_next      = pos_reg + 8'd1;
            if (col_reg == COL_LAST)
            begin
                col_next = 7'd0;
                row_next = row_inc(row_reg);
            end
            else
            begin
                col_next = col_reg + 7'd1;
            end
        end

        // state only changes when the item leaves the input register
        if (!move)
        begin
            row_next = row_reg;
            col_next = col_reg;
            pos_next = pos_reg;
        end
    end

    // control and editor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            row_reg  <= 5'd0;
            col_reg  <= 7'd0;
            pos_reg  <= 8'd0;
        end
        else
        begin
            full_reg <= full_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            pos_reg  <= pos_next;
        end
    end

    // scancode payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= scancode;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sle_outq.sv
// output queue: holds the results of one scancode and sends one per cycle while echo_stall is low
// depends on sle_pkg
`default_nettype none

module sle_outq
    import sle_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire batch_t batch,
    output logic      take,
    output logic      echo_valid,
    input  wire logic echo_stall,
    output logic      target,
    output logic [10:0] location,
    output logic [15:0] value,
    output logic      line_done,
    output logic      last
);

    res_t [2:0] item_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       sent;
    res_t       cur;

    // current transfer
    assign cur        = item_reg[idx_reg];
    assign echo_valid = (cnt_reg != 2'd0);
    assign last       = echo_valid && (idx_reg == cnt_reg - 2'd1);
    assign sent       = echo_valid && !echo_stall;
    assign take       = !echo_valid || (sent && last);

    assign target    = cur.target;
    assign location  = cur.location;
    assign value     = cur.value;
    assign line_done = cur.line_done;

    // count and index sequencing
    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (batch.load)
        begin
            cnt_next = batch.cnt;
            idx_next = 2'd0;
        end
        else if (sent)
        begin
            if (last)
            begin
                cnt_next = 2'd0;
                idx_next = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (batch.load)
        begin
            item_reg <= batch.item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/scancode_line_editor_echo.sv
// top level of the scancode line editor with screen echo
// depends on sle_pkg, sle_cfg, sle_core, sle_outq
//
//  channel | signals                                   | transfer when
//  key     | key_valid, key_stall, scancode            | key_valid && !key_stall
//  echo    | echo_valid, echo_stall, target, location, | echo_valid && !echo_stall
//          | value, line_done, last                    |
//  apb     | psel, penable, pwrite, paddr, pwdata      | psel && penable && pwrite
//
// a scancode waits in the input register until the output queue takes it, then its 0 to 3 results
// leave the output queue at one per cycle while echo_stall is low
// the output queue sets the rate: the next scancode moves on in the cycle
// the last result of the one before is taken
// reset clears the cursor and the line position and sets line_capacity to 256
// a stall on echo holds the queue and then stalls key
`default_nettype none

module scancode_line_editor_echo
    import sle_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25,
    parameter int LINE_MAX    = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        key_valid,
    output logic             key_stall,
    input  wire logic [7:0]  scancode,
    output logic             echo_valid,
    input  wire logic        echo_stall,
    output logic             target,
    output logic [10:0]      location,
    output logic [15:0]      value,
    output logic             line_done,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [8:0] line_capacity;
    logic       take;
    batch_t     batch;

    // configuration register
    sle_cfg u_cfg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .line_capacity (line_capacity)
    );

    // editor state and result computation
    sle_core #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .LINE_MAX    (LINE_MAX)
    ) u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_valid     (key_valid),
        .key_stall     (key_stall),
        .scancode      (scancode),
        .line_capacity (line_capacity),
        .take          (take),
        .batch         (batch)
    );

    // result serializer
    sle_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .batch      (batch),
        .take       (take),
        .echo_valid (echo_valid),
        .echo_stall (echo_stall),
        .target     (target),
        .location   (location),
        .value      (value),
        .line_done  (line_done),
        .last       (last)
    );

endmodule

`default_nettype wire

FILE: rtl/sle_checker.sv
// port-level checks for the scancode line editor, bound to the top level
// depends on sle_pkg and scancode_line_editor_echo
`default_nettype none

module sle_checker
    import sle_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        echo_valid,
    input wire logic        echo_stall,
    input wire logic        target,
    input wire logic [10:0] location,
    input wire logic [15:0] value,
    input wire logic        line_done,
    input wire logic        last
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        echo_valid && echo_stall |=> echo_valid && $stable(location) && $stable(value)
            && $stable(target) && $stable(last))
        else $error("echo payload changed while stalled");

    // nothing leaves during reset
    a_reset: assert property (@(posedge clk) !rst_n |-> !echo_valid)
        else $error("echo valid during reset");

    // a terminator is a line write of zero and the last result of its scancode
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        echo_valid && line_done |-> last && target == TGT_LINE && value == 16'h0000)
        else $error("terminator not a lone line write");

    // a stored character is always followed by its echo
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        echo_valid && !echo_stall && target == TGT_LINE && !line_done |->
            !last ##1 (echo_valid && target == TGT_SCREEN))
        else $error("line write without screen echo");

    // screen writes carry the text attribute
    a_attr: assert property (@(posedge clk) disable iff (!rst_n)
        echo_valid && target == TGT_SCREEN |-> value[15:8] == ATTR_TEXT && !line_done)
        else $error("bad screen write attribute");

endmodule

bind scancode_line_editor_echo sle_checker u_sle_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .echo_valid (echo_valid),
    .echo_stall (echo_stall),
    .target     (target),
    .location   (location),
    .value      (value),
    .line_done  (line_done),
    .last       (last)
);

`default_nettype wire
